### design/spiee_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the spi eeprom access sequencer
// no dependencies; used by every module of the block
package spiee_pkg;

  // serial eeprom command bytes
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_RDSR  = 8'h05;

  // write-in-progress bit of the status byte
  localparam int unsigned WIP_BIT = 0;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // one classified tick as it travels from front to back
  typedef struct packed {
    logic        start;      // request present on this tick
    logic        is_write;   // write access, starts with write enable
    logic [7:0]  first_cmd;  // first command byte of the access
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        miso;
  } item_t;

endpackage

### design/spiee_front.sv
`timescale 1ns / 1ps
// front end: takes one tick per cycle while the queue is not full, and classifies its request
// depends on spiee_pkg
module spiee_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_valid,
  input  logic                 in_mode,
  input  logic [15:0]          in_address,
  input  logic [7:0]           in_write_data,
  input  logic                 in_miso,
  input  logic                 q_full,
  output logic                 q_push,
  output spiee_pkg::item_t     q_item
);
  import spiee_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.start      = in_req_valid;
    q_item.is_write   = in_mode;
    q_item.first_cmd  = in_mode ? CMD_WREN : CMD_READ;
    q_item.address    = in_address;
    q_item.write_data = in_write_data;
    q_item.miso       = in_miso;
  end

endmodule

### design/spiee_queue.sv
`timescale 1ns / 1ps
// short fifo between the front and the back
// depends on spiee_pkg for the item type
module spiee_queue #(
  parameter int unsigned DEPTH = spiee_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spiee_pkg::item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output spiee_pkg::item_t  q_item
);
  import spiee_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> count_r != '0)
    else $error("full queue lost its entries without a pop");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

### design/spiee_back.sv
`timescale 1ns / 1ps
// back end: spi mode 0 sequencer for the eeprom commands plus result register
// depends on spiee_pkg
module spiee_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  spiee_pkg::item_t  q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_sclk,
  output logic              out_mosi,
  output logic              out_cs_n,
  output logic              out_busy_res,
  output logic              out_read_valid,
  output logic [7:0]        out_read_data,
  output logic              out_write_done
);
  import spiee_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_RD_CMD = 4'd1,
    PH_RD_AH  = 4'd2,
    PH_RD_AL  = 4'd3,
    PH_RD_DAT = 4'd4,
    PH_WREN   = 4'd5,
    PH_WR_GAP = 4'd6,
    PH_WR_CMD = 4'd7,
    PH_WR_AH  = 4'd8,
    PH_WR_AL  = 4'd9,
    PH_WR_DAT = 4'd10,
    PH_ST_GAP = 4'd11,
    PH_ST_CMD = 4'd12,
    PH_ST_DAT = 4'd13
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  bit_count_r, bit_count_nxt;
  logic        clock_level_r, clock_level_nxt;
  logic [7:0]  tx_shift_r, tx_shift_nxt;
  logic [7:0]  rx_shift_r, rx_shift_nxt;
  logic [15:0] addr_hold_r, addr_hold_nxt;
  logic [7:0]  data_hold_r, data_hold_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        sclk_r, sclk_nxt;
  logic        mosi_r, mosi_nxt;
  logic        cs_n_r, cs_n_nxt;
  logic        busy_r, busy_nxt;
  logic        rv_r, rv_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic        wd_r, wd_nxt;

  logic        take;
  logic        start_en;
  phase_t      start_ph;
  logic [7:0]  start_val;
  logic        desel_en;
  phase_t      desel_ph;

  // the result register frees up when it is empty or being taken
  assign take  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = take;

  always_comb begin
    phase_nxt       = phase_r;
    bit_count_nxt   = bit_count_r;
    clock_level_nxt = clock_level_r;
    tx_shift_nxt    = tx_shift_r;
    rx_shift_nxt    = rx_shift_r;
    addr_hold_nxt   = addr_hold_r;
    data_hold_nxt   = data_hold_r;
    sclk_nxt        = 1'b0;
    mosi_nxt        = 1'b0;
    cs_n_nxt        = 1'b1;
    rv_nxt          = 1'b0;
    rd_nxt          = '0;
    wd_nxt          = 1'b0;
    start_en        = 1'b0;
    start_ph        = PH_IDLE;
    start_val       = '0;
    desel_en        = 1'b0;
    desel_ph        = PH_IDLE;

    case (phase_r)
      PH_IDLE: begin
        if (q_item.start) begin
          addr_hold_nxt = q_item.address;
          data_hold_nxt = q_item.write_data;
          start_en      = 1'b1;
          start_ph      = q_item.is_write ? PH_WREN : PH_RD_CMD;
          start_val     = q_item.first_cmd;
        end
      end
      PH_WR_GAP: begin
        start_en  = 1'b1;
        start_ph  = PH_WR_CMD;
        start_val = CMD_WRITE;
      end
      PH_ST_GAP: begin
        start_en  = 1'b1;
        start_ph  = PH_ST_CMD;
        start_val = CMD_RDSR;
      end
      PH_RD_CMD, PH_RD_AH, PH_RD_AL, PH_RD_DAT, PH_WREN, PH_WR_CMD,
      PH_WR_AH, PH_WR_AL, PH_WR_DAT, PH_ST_CMD, PH_ST_DAT: begin
        if (!clock_level_r) begin
          // high half of the bit: sample miso
          rx_shift_nxt    = {rx_shift_r[6:0], q_item.miso};
          clock_level_nxt = 1'b1;
          cs_n_nxt        = 1'b0;
          sclk_nxt        = 1'b1;
          mosi_nxt        = tx_shift_r[7];
        end else if (bit_count_r != 3'd7) begin
          bit_count_nxt   = bit_count_r + 3'd1;
          tx_shift_nxt    = {tx_shift_r[6:0], 1'b0};
          clock_level_nxt = 1'b0;
          cs_n_nxt        = 1'b0;
          mosi_nxt        = tx_shift_r[6];
        end else begin
          // byte finished: pick the next byte or close the window
          case (phase_r)
            PH_RD_CMD: begin
              start_en  = 1'b1;
              start_ph  = PH_RD_AH;
              start_val = addr_hold_r[15:8];
            end
            PH_RD_AH: begin
              start_en  = 1'b1;
              start_ph  = PH_RD_AL;
              start_val = addr_hold_r[7:0];
            end
            PH_RD_AL: begin
              start_en  = 1'b1;
              start_ph  = PH_RD_DAT;
            end
            PH_RD_DAT: begin
              desel_en = 1'b1;
              rv_nxt   = 1'b1;
              rd_nxt   = rx_shift_r;
            end
            PH_WREN: begin
              desel_en = 1'b1;
              desel_ph = PH_WR_GAP;
            end
            PH_WR_CMD: begin
              start_en  = 1'b1;
              start_ph  = PH_WR_AH;
              start_val = addr_hold_r[15:8];
            end
            PH_WR_AH: begin
              start_en  = 1'b1;
              start_ph  = PH_WR_AL;
              start_val = addr_hold_r[7:0];
            end
            PH_WR_AL: begin
              start_en  = 1'b1;
              start_ph  = PH_WR_DAT;
              start_val = data_hold_r;
            end
            PH_WR_DAT: begin
              desel_en = 1'b1;
              desel_ph = PH_ST_GAP;
            end
            PH_ST_CMD: begin
              start_en  = 1'b1;
              start_ph  = PH_ST_DAT;
            end
            default: begin
              // status byte: poll again while write is in progress
              desel_en = 1'b1;
              if (rx_shift_r[WIP_BIT]) begin
                desel_ph = PH_ST_GAP;
              end else begin
                wd_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
        desel_en = 1'b1;
      end
    endcase

    if (start_en) begin
      phase_nxt       = start_ph;
      tx_shift_nxt    = start_val;
      bit_count_nxt   = '0;
      clock_level_nxt = 1'b0;
      cs_n_nxt        = 1'b0;
      sclk_nxt        = 1'b0;
      mosi_nxt        = start_val[7];
    end
    if (desel_en) begin
      phase_nxt       = desel_ph;
      bit_count_nxt   = '0;
      clock_level_nxt = 1'b0;
      cs_n_nxt        = 1'b1;
      sclk_nxt        = 1'b0;
      mosi_nxt        = 1'b0;
    end

    busy_nxt      = (phase_nxt != PH_IDLE);
    out_valid_nxt = take || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_count_r   <= '0;
      clock_level_r <= 1'b0;
      tx_shift_r    <= '0;
      rx_shift_r    <= '0;
      addr_hold_r   <= '0;
      data_hold_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        phase_r       <= phase_nxt;
        bit_count_r   <= bit_count_nxt;
        clock_level_r <= clock_level_nxt;
        tx_shift_r    <= tx_shift_nxt;
        rx_shift_r    <= rx_shift_nxt;
        addr_hold_r   <= addr_hold_nxt;
        data_hold_r   <= data_hold_nxt;
      end
    end
    if (take) begin
      sclk_r <= sclk_nxt;
      mosi_r <= mosi_nxt;
      cs_n_r <= cs_n_nxt;
      busy_r <= busy_nxt;
      rv_r   <= rv_nxt;
      rd_r   <= rd_nxt;
      wd_r   <= wd_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sclk       = sclk_r;
  assign out_mosi       = mosi_r;
  assign out_cs_n       = cs_n_r;
  assign out_busy_res   = busy_r;
  assign out_read_valid = rv_r;
  assign out_read_data  = rd_r;
  assign out_write_done = wd_r;

  a_done_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(rv_r && wd_r))
    else $error("read and write completion in the same tick");

  a_deselect_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && cs_n_r) |-> (!sclk_r && !mosi_r))
    else $error("serial lines active while deselected");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (rv_r || wd_r)) |-> (!busy_r && cs_n_r))
    else $error("completion pulse while still busy or selected");

  a_idle_no_clock: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> !clock_level_r)
    else $error("idle with serial clock high");

endmodule

### design/spi_eeprom_access_sequencer_unit.sv
`timescale 1ns / 1ps
// spi eeprom access sequencer: one tick in, one line state out, every cycle while neither side stalls
// an accepted tick's result passes the queue entry, then the result register
// throughput: one tick per cycle unless out_stall holds the result register, one sequencer step per tick
// the two-entry queue takes two more ticks while a result waits on out_stall, then stalls input
// reset (rst_n low, synchronous): idle, queue and result register empty
module spi_eeprom_access_sequencer_unit #(
  parameter int unsigned QDEPTH = spiee_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_valid,
  input  logic        in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_miso,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_sclk,
  output logic        out_mosi,
  output logic        out_cs_n,
  output logic        out_busy_res,
  output logic        out_read_valid,
  output logic [7:0]  out_read_data,
  output logic        out_write_done
);
  import spiee_pkg::*;

  logic  q_full;
  logic  q_push;
  item_t push_item;
  logic  q_pop;
  logic  q_valid;
  item_t q_item;

  spiee_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_valid  (in_req_valid),
    .in_mode       (in_mode),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_miso       (in_miso),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  spiee_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  spiee_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sclk       (out_sclk),
    .out_mosi       (out_mosi),
    .out_cs_n       (out_cs_n),
    .out_busy_res   (out_busy_res),
    .out_read_valid (out_read_valid),
    .out_read_data  (out_read_data),
    .out_write_done (out_write_done)
  );

endmodule

### dv/spi_eeprom_access_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// testbench for spi_eeprom_access_sequencer_unit: drives serial ticks that carry the requests,
// predicts the line state of every tick and checks it; depends on spiee_pkg and the rtl
module spi_eeprom_access_sequencer_unit_tb;
  import spiee_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_TICKS = 1700;

  typedef enum logic [4:0] {
    PH_IDLE, PH_RD_CMD, PH_RD_AH, PH_RD_AL, PH_RD_DAT, PH_WREN, PH_WR_GAP,
    PH_WR_CMD, PH_WR_AH, PH_WR_AL, PH_WR_DAT, PH_ST_GAP, PH_ST_CMD, PH_ST_DAT
  } seq_phase_e;

  typedef struct packed {
    logic        req;
    logic        mode;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        miso;
  } tick_t;

  typedef struct packed {
    logic       sclk;
    logic       mosi;
    logic       cs_n;
    logic       busy;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       wr_done;
  } line_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_valid = 1'b0;
  logic        in_mode = 1'b0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        in_miso = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_sclk;
  logic        out_mosi;
  logic        out_cs_n;
  logic        out_busy_res;
  logic        out_read_valid;
  logic [7:0]  out_read_data;
  logic        out_write_done;

  spi_eeprom_access_sequencer_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_valid  (in_req_valid),
    .in_mode       (in_mode),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_miso       (in_miso),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sclk      (out_sclk),
    .out_mosi      (out_mosi),
    .out_cs_n      (out_cs_n),
    .out_busy_res  (out_busy_res),
    .out_read_valid(out_read_valid),
    .out_read_data (out_read_data),
    .out_write_done(out_write_done)
  );

  always #5 clk = ~clk;

  // sequencer state as predicted from accepted requests
  seq_phase_e  mdl_phase = PH_IDLE;
  logic [2:0]  mdl_bits  = '0;
  logic        mdl_level = 1'b0;
  logic [7:0]  mdl_tx    = '0;
  logic [7:0]  mdl_rx    = '0;
  logic [15:0] mdl_addr  = '0;
  logic [7:0]  mdl_data  = '0;

  line_state_t expected_lines[$];
  int          fail_count  = 0;
  int          ticks_sent  = 0;
  int          burst_left  = 0;
  int          cycle_count = 0;
  int          stall_style = 0;

  function automatic void load_byte(seq_phase_e ph, logic [7:0] value, inout line_state_t r);
    mdl_phase = ph;
    mdl_tx    = value;
    mdl_bits  = '0;
    mdl_level = 1'b0;
    r.cs_n    = 1'b0;
    r.sclk    = 1'b0;
    r.mosi    = value[7];
  endfunction

  function automatic void drop_select(seq_phase_e ph, inout line_state_t r);
    mdl_phase = ph;
    mdl_bits  = '0;
    mdl_level = 1'b0;
    r.cs_n    = 1'b1;
    r.sclk    = 1'b0;
    r.mosi    = 1'b0;
  endfunction

  function automatic line_state_t predict_line(tick_t t);
    line_state_t r;
    r = '0;
    r.cs_n = 1'b1;
    case (mdl_phase)
      PH_IDLE: begin
        if (t.req) begin
          mdl_addr = t.addr;
          mdl_data = t.wdata;
          if (t.mode) load_byte(PH_WREN, CMD_WREN, r);
          else load_byte(PH_RD_CMD, CMD_READ, r);
        end
      end
      PH_WR_GAP: load_byte(PH_WR_CMD, CMD_WRITE, r);
      PH_ST_GAP: load_byte(PH_ST_CMD, CMD_RDSR, r);
      default: begin
        if (!mdl_level) begin
          // high half of the bit: sample miso
          mdl_rx    = {mdl_rx[6:0], t.miso};
          mdl_level = 1'b1;
          r.cs_n    = 1'b0;
          r.sclk    = 1'b1;
          r.mosi    = mdl_tx[7];
        end else if (mdl_bits < 3'd7) begin
          mdl_bits  = mdl_bits + 3'd1;
          mdl_tx    = mdl_tx << 1;
          mdl_level = 1'b0;
          r.cs_n    = 1'b0;
          r.sclk    = 1'b0;
          r.mosi    = mdl_tx[7];
        end else begin
          case (mdl_phase)
            PH_RD_CMD: load_byte(PH_RD_AH, mdl_addr[15:8], r);
            PH_RD_AH:  load_byte(PH_RD_AL, mdl_addr[7:0], r);
            PH_RD_AL:  load_byte(PH_RD_DAT, 8'h00, r);
            PH_RD_DAT: begin
              drop_select(PH_IDLE, r);
              r.rd_valid = 1'b1;
              r.rd_data  = mdl_rx;
            end
            PH_WREN:   drop_select(PH_WR_GAP, r);
            PH_WR_CMD: load_byte(PH_WR_AH, mdl_addr[15:8], r);
            PH_WR_AH:  load_byte(PH_WR_AL, mdl_addr[7:0], r);
            PH_WR_AL:  load_byte(PH_WR_DAT, mdl_data, r);
            PH_WR_DAT: drop_select(PH_ST_GAP, r);
            PH_ST_CMD: load_byte(PH_ST_DAT, 8'h00, r);
            default: begin
              // status byte: poll again while the write is in progress
              if (mdl_rx[WIP_BIT]) begin
                drop_select(PH_ST_GAP, r);
              end else begin
                drop_select(PH_IDLE, r);
                r.wr_done = 1'b1;
              end
            end
          endcase
        end
      end
    endcase
    r.busy = (mdl_phase != PH_IDLE);
    return r;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.req   = 1'b0;
    t.mode  = 1'($urandom);
    t.addr  = 16'($urandom);
    t.wdata = 8'($urandom);
    t.miso  = 1'($urandom);
    return t;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0h actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    in_valid      <= 1'b1;
    in_req_valid  <= t.req;
    in_mode       <= t.mode;
    in_address    <= t.addr;
    in_write_data <= t.wdata;
    in_miso       <= t.miso;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_lines.push_back(predict_line(t));
    ticks_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(random_tick());
  endtask

  // one full access; miso supplies the read byte and holds the busy bit for some polls
  task automatic run_access(input logic mode, input logic [15:0] addr,
                            input logic [7:0] wdata, input logic [7:0] rd_byte,
                            input int polls, input int noise_pct);
    tick_t t;
    int    polls_left;
    polls_left = polls;
    t = random_tick();
    t.req   = 1'b1;
    t.mode  = mode;
    t.addr  = addr;
    t.wdata = wdata;
    send_tick(t);
    while (mdl_phase != PH_IDLE) begin
      t = random_tick();
      t.req = ($urandom_range(0, 99) < noise_pct);
      if (mdl_phase == PH_RD_DAT && !mdl_level) t.miso = rd_byte[3'd7 - mdl_bits];
      if (mdl_phase == PH_ST_DAT && !mdl_level && mdl_bits == 3'd7) begin
        t.miso = (polls_left > 0);
        if (polls_left > 0) polls_left--;
      end
      send_tick(t);
    end
  endtask

  task automatic test_idle_ticks();
    tick_t t;
    t = '1;
    t.req = 1'b0;
    send_tick(t);
    t = '0;
    send_tick(t);
    idle_ticks(4);
  endtask

  task automatic test_read_extremes();
    run_access(1'b0, 16'h0000, 8'hff, 8'hff, 0, 0);
    run_access(1'b0, 16'hffff, 8'h00, 8'h00, 0, 0);
    run_access(1'b0, 16'ha55a, 8'h3c, 8'h5a, 0, 0);
  endtask

  task automatic test_write_extremes();
    run_access(1'b1, 16'h0000, 8'hff, 8'h00, 0, 0);
    run_access(1'b1, 16'hffff, 8'h00, 8'hff, 3, 0);
    run_access(1'b1, 16'h5aa5, 8'ha5, 8'h00, 1, 0);
  endtask

  task automatic test_busy_requests();
    // requests on every busy tick, deselect ticks included, must be dropped
    run_access(1'b0, 16'h1234, 8'h56, 8'h81, 0, 100);
    run_access(1'b1, 16'h4321, 8'h65, 8'h18, 2, 100);
    idle_ticks(2);
  endtask

  task automatic test_random_traffic();
    int polls;
    while (ticks_sent < RANDOM_TICKS) begin
      if ($urandom_range(0, 1)) idle_ticks($urandom_range(0, 3));
      polls = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : $urandom_range(0, 1);
      run_access(1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), polls,
                 $urandom_range(0, 20));
    end
  endtask

  // receiver stall: drawn in one of four styles, re-picked at random as the test runs
  always @(posedge clk) begin
    if (cycle_count % 50 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 6);
      default: out_stall <= (cycle_count % 8 < 3);
    endcase
  end

  always @(posedge clk) begin
    line_state_t exp_line;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        $error("line state with no request pending");
        fail_count++;
      end else begin
        exp_line = expected_lines.pop_front();
        check_field("sclk", exp_line.sclk, out_sclk);
        check_field("mosi", exp_line.mosi, out_mosi);
        check_field("cs_n", exp_line.cs_n, out_cs_n);
        check_field("busy_res", exp_line.busy, out_busy_res);
        check_field("read_valid", exp_line.rd_valid, out_read_valid);
        check_field("read_data", exp_line.rd_data, out_read_data);
        check_field("write_done", exp_line.wr_done, out_write_done);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_read_extremes();
    test_write_extremes();
    test_busy_requests();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
